@@ design/lkv_pkg.sv @@
package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;

	localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	typedef enum logic {
		ACT_GET = 1'b0,
		ACT_PUT = 1'b1
	} action_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

endpackage

@@ design/lkv_cell.sv @@
module lkv_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    upd,
	input  logic                    stop,
	input  logic                    below,
	input  lkv_pkg::entry_t         prev,
	input  logic [lkv_pkg::KEY_W-1:0] key,
	output lkv_pkg::entry_t         cur,
	output logic                    hit,
	output logic                    shift_o
);

	logic                        valid_q;
	logic [lkv_pkg::KEY_W-1:0]   key_q;
	logic [lkv_pkg::VAL_W-1:0]   value_q;

	assign shift_o = stop | below;
	assign hit     = valid_q && (key_q == key);

	assign cur.valid = valid_q;
	assign cur.key   = key_q;
	assign cur.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd && shift_o) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && shift_o) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

endmodule

@@ design/lru_key_value_cache.sv @@
// Channel  | Direction | tdata                                  | tuser
// s_*      | in        | lookup_key [31:0], write_value [63:32] | action (0 get, 1 put)
// m_*      | out       | read_value [31:0]                      | found
// capacity | in        | capacity_wdata [4:0] on capacity_we    | -
// An item is captured in the input register; the run state then does the key
// compare in every cell and the recency shift down the cell row. A get waits in
// the run state while an earlier result still sits unread in the output register.
// Reset empties all cells and sets capacity to 16; no clearing pass.
// Cells are kept in recency order, most recent in cell 0.
module lru_key_value_cache (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      capacity_we,
	input  logic [lkv_pkg::CAP_W-1:0] capacity_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [63:0]               s_tdata,   // lookup_key, write_value
	input  logic                      s_tuser,   // action
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,   // read_value
	output logic                      m_tuser    // found
);

	localparam int N = lkv_pkg::ENTRIES;

	lkv_pkg::state_t                 state_q, state_d;
	logic [lkv_pkg::CAP_W-1:0]       cap_q;
	logic [lkv_pkg::CNT_W-1:0]       count_q;
	logic                            act_s1;
	logic [lkv_pkg::KEY_W-1:0]       key_s1;
	logic [lkv_pkg::VAL_W-1:0]       wval_s1;
	logic                            m_tvalid_q;
	logic                            found_q;
	logic [lkv_pkg::VAL_W-1:0]       rdata_q;

	lkv_pkg::entry_t                 chain [N+1];
	logic [N:0]                      sh;
	logic [N-1:0]                    hit;
	logic [N-1:0]                    stop;
	logic [N-1:0]                    valid_vec;
	logic                            hit_any;
	logic [lkv_pkg::VAL_W-1:0]       hit_val;
	logic                            commit;
	logic                            evict;
	logic [lkv_pkg::CMP_W-1:0]       eff_cap;
	logic [lkv_pkg::IDX_W-1:0]       last_idx;
	logic                            accept;

	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lkv_pkg::ST_IDLE: if (s_tvalid) state_d = lkv_pkg::ST_RUN;
			lkv_pkg::ST_RUN:  if (commit) state_d = lkv_pkg::ST_IDLE;
			default:          state_d = lkv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			lkv_pkg::ST_IDLE: s_tready = 1'b1;
			lkv_pkg::ST_RUN:  commit = (act_s1 == lkv_pkg::ACT_PUT) || !m_tvalid_q || m_tready;
			default:          s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (capacity_we) begin
			cap_q <= capacity_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= s_tuser;
			key_s1  <= s_tdata[31:0];
			wval_s1 <= s_tdata[63:32];
		end
	end

	always_comb begin
		hit_val = '0;
		for (int i = 0; i < N; i++) begin
			if (hit[i]) hit_val = hit_val | chain[i+1].value;
		end
	end

	assign hit_any = |hit;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lkv_pkg::CMP_W'(1);
		end else if (lkv_pkg::CMP_W'(cap_q) > lkv_pkg::CMP_W'(N)) begin
			eff_cap = lkv_pkg::CMP_W'(N);
		end else begin
			eff_cap = lkv_pkg::CMP_W'(cap_q);
		end
	end

	assign evict    = lkv_pkg::CMP_W'(count_q) >= eff_cap;
	assign last_idx = evict ? lkv_pkg::IDX_W'(count_q - 1'b1) : lkv_pkg::IDX_W'(count_q);

	always_comb begin
		priority if (hit_any) begin
			stop = hit;
		end else if (act_s1 == lkv_pkg::ACT_PUT) begin
			for (int i = 0; i < N; i++) stop[i] = (last_idx == lkv_pkg::IDX_W'(i));
		end else begin
			stop = '0;
		end
	end

	assign chain[0].valid = 1'b1;
	assign chain[0].key   = key_s1;
	assign chain[0].value = (act_s1 == lkv_pkg::ACT_PUT) ? wval_s1 : hit_val;
	assign sh[N]          = 1'b0;

	for (genvar g = 0; g < N; g++) begin : g_cell
		lkv_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.upd     (commit),
			.stop    (stop[g]),
			.below   (sh[g+1]),
			.prev    (chain[g]),
			.key     (key_s1),
			.cur     (chain[g+1]),
			.hit     (hit[g]),
			.shift_o (sh[g])
		);
		assign valid_vec[g] = chain[g+1].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit && (act_s1 == lkv_pkg::ACT_PUT) && !hit_any && !evict) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit && (act_s1 == lkv_pkg::ACT_GET)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && (act_s1 == lkv_pkg::ACT_GET)) begin
			found_q <= hit_any;
			rdata_q <= hit_any ? hit_val : lkv_pkg::MISS_VALUE;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = rdata_q;
	assign m_tuser  = found_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		lkv_pkg::CMP_W'(count_q) <= lkv_pkg::CMP_W'(N))
		else $error("occupancy beyond entry count");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("valid cells disagree with occupancy");

	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("key present in more than one cell");

	a_put_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (act_s1 == lkv_pkg::ACT_PUT) && !m_tvalid_q) |=> !m_tvalid_q)
		else $error("put produced a result");

endmodule
